>>> rtl/core/drbt_pkg.sv
package drbt_pkg;

  localparam int ADDR_W    = 48;
  localparam int LAT_W     = 12;
  localparam int CNT_W     = 48;
  localparam int CYC_W     = 10;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 3;

  // bank count and row size are powers of two
  localparam int NUM_BANKS = 16;
  localparam int ROW_BYTES = 1024;
  localparam int BANK_W    = $clog2(NUM_BANKS);
  localparam int ROW_LOG2  = $clog2(ROW_BYTES);

  localparam logic [CFG_IDX_W-1:0] REG_ROW_MODEL_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_POLICY_CLOSED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_SIZE_LOG2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVATE_CYCLES    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_CYCLES      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PRECHARGE_CYCLES   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSFER_CYCLES    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_LATENCY      = 3'd7;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_FIXED    = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_HIT      = 2'd2,
    KIND_CONFLICT = 2'd3
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] line_address;
    logic              is_write;
  } req_t;

  typedef struct packed {
    logic [LAT_W-1:0] latency;
    logic [1:0]       access_kind;
    logic [CNT_W-1:0] read_count;
    logic [CNT_W-1:0] write_count;
    logic [CNT_W-1:0] read_delay_total;
    logic [CNT_W-1:0] write_delay_total;
  } rsp_t;

  typedef struct packed {
    logic             valid;
    logic             is_write;
    logic [LAT_W-1:0] latency;
  } stat_upd_t;

  typedef struct packed {
    logic [CNT_W-1:0] read_count;
    logic [CNT_W-1:0] write_count;
    logic [CNT_W-1:0] read_delay_total;
    logic [CNT_W-1:0] write_delay_total;
  } stat_tot_t;

endpackage

>>> rtl/core/drbt_ram.sv
module drbt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/drbt_div.sv
module drbt_div #(
  parameter int AW = 48
) (
  input  logic [AW-1:0]               addr,
  input  logic [3:0]                  line_size_log2,
  output logic [drbt_pkg::BANK_W-1:0] bank,
  output logic [AW-1:0]               row
);

  logic [4:0] lines_log2;
  logic [4:0] shamt;

  // lines per row floored at one when the line is larger than a row
  always_comb begin
    lines_log2 = ({1'b0, line_size_log2} >= 5'(drbt_pkg::ROW_LOG2)) ? 5'd0
               : 5'(drbt_pkg::ROW_LOG2) - {1'b0, line_size_log2};
    shamt      = lines_log2 + 5'(drbt_pkg::BANK_W);
    bank       = addr[drbt_pkg::BANK_W-1:0];
    row        = addr >> shamt;
  end

endmodule

>>> rtl/core/drbt_stats.sv
module drbt_stats (
  input  logic                clk,
  input  logic                rst,
  input  drbt_pkg::stat_upd_t upd,
  output drbt_pkg::stat_tot_t tot
);

  function automatic logic [drbt_pkg::CNT_W-1:0] sat_add(
    input logic [drbt_pkg::CNT_W-1:0] a,
    input logic [drbt_pkg::LAT_W-1:0] b
  );
    logic [drbt_pkg::CNT_W:0] s;
    s = {1'b0, a} + (drbt_pkg::CNT_W+1)'(b);
    return s[drbt_pkg::CNT_W] ? drbt_pkg::CNT_MAX : s[drbt_pkg::CNT_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      tot <= '0;
    end else if (upd.valid) begin
      if (upd.is_write) begin
        tot.write_count       <= sat_add(tot.write_count, drbt_pkg::LAT_W'(1));
        tot.write_delay_total <= sat_add(tot.write_delay_total, upd.latency);
      end else begin
        tot.read_count        <= sat_add(tot.read_count, drbt_pkg::LAT_W'(1));
        tot.read_delay_total  <= sat_add(tot.read_delay_total, upd.latency);
      end
    end
  end

endmodule

>>> rtl/core/dram_bank_row_buffer_timing.sv
// DRAM bank row-buffer timing model. Each request transaction carries a cache-line
// address and a read/write flag; each response transaction returns the latency of
// that access, its kind (fixed, bank empty, row hit, row conflict) and saturating
// read and write access counts and delay totals that include it. Bank is the low
// address bits (address modulo NUM_BANKS) and row is the address shifted right by
// log2 of lines-per-row plus log2 of NUM_BANKS; NUM_BANKS and ROW_BYTES are package
// constants and powers of two. The open row of each bank lives in a RAM with
// registered read: it is read in the cycle the request is taken, then compared and
// written back. One transaction is in flight at a time: ST_IDLE takes the request
// and reads the RAM and ST_EVAL evaluates and loads the response register; ST_EVAL
// is extended while a stalled response still holds that register. The user must
// write configuration through cfg_we/cfg_index/cfg_data only while no transaction
// is outstanding; the block itself does not enforce it.
module dram_bank_row_buffer_timing #(
  parameter int ADDR_BITS = 48
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [drbt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [drbt_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  drbt_pkg::req_t                     req,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output drbt_pkg::rsp_t                     rsp
);

  localparam int AW = (ADDR_BITS < drbt_pkg::ADDR_W) ? ADDR_BITS : drbt_pkg::ADDR_W;
  localparam int BW = drbt_pkg::BANK_W;

  logic                         row_model_enable;
  logic                         page_policy_closed;
  logic [3:0]                   line_size_log2;
  logic [drbt_pkg::CYC_W-1:0]   activate_cycles;
  logic [drbt_pkg::CYC_W-1:0]   column_cycles;
  logic [drbt_pkg::CYC_W-1:0]   precharge_cycles;
  logic [drbt_pkg::CYC_W-1:0]   transfer_cycles;
  logic [drbt_pkg::LAT_W-1:0]   fixed_latency;

  drbt_pkg::state_t             state;
  drbt_pkg::state_t             state_next;

  logic                         accept;
  logic [AW-1:0]                addr;
  logic [BW-1:0]                bank;
  logic [AW-1:0]                row;

  logic                         ram_re;
  logic                         ram_we;
  logic [AW-1:0]                open_row;
  logic [drbt_pkg::NUM_BANKS-1:0] bank_valid;
  logic                         is_write;
  logic                         commit;
  logic                         row_hit;

  logic [drbt_pkg::LAT_W-1:0]   lat;
  drbt_pkg::kind_t              kind;
  logic [drbt_pkg::LAT_W-1:0]   latency;
  logic [1:0]                   access_kind;

  drbt_pkg::stat_upd_t          upd;
  drbt_pkg::stat_tot_t          tot;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_model_enable   <= 1'b0;
      page_policy_closed <= 1'b0;
      line_size_log2     <= 4'd6;
      activate_cycles    <= drbt_pkg::CYC_W'(45);
      column_cycles      <= drbt_pkg::CYC_W'(45);
      precharge_cycles   <= drbt_pkg::CYC_W'(45);
      transfer_cycles    <= drbt_pkg::CYC_W'(10);
      fixed_latency      <= drbt_pkg::LAT_W'(100);
    end else if (cfg_we) begin
      unique case (cfg_index)
        drbt_pkg::REG_ROW_MODEL_ENABLE:   row_model_enable   <= cfg_data[0];
        drbt_pkg::REG_PAGE_POLICY_CLOSED: page_policy_closed <= cfg_data[0];
        drbt_pkg::REG_LINE_SIZE_LOG2:     line_size_log2     <= cfg_data[3:0];
        drbt_pkg::REG_ACTIVATE_CYCLES:    activate_cycles    <= cfg_data[9:0];
        drbt_pkg::REG_COLUMN_CYCLES:      column_cycles      <= cfg_data[9:0];
        drbt_pkg::REG_PRECHARGE_CYCLES:   precharge_cycles   <= cfg_data[9:0];
        drbt_pkg::REG_TRANSFER_CYCLES:    transfer_cycles    <= cfg_data[9:0];
        drbt_pkg::REG_FIXED_LATENCY:      fixed_latency      <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= drbt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      drbt_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = drbt_pkg::ST_EVAL;
        end
      end
      drbt_pkg::ST_EVAL: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = drbt_pkg::ST_IDLE;
        end
      end
      default: state_next = drbt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall = (state != drbt_pkg::ST_IDLE);
    accept    = req_valid && !req_stall;
    ram_re    = accept && row_model_enable;
    commit    = (state == drbt_pkg::ST_EVAL) && (!rsp_valid || !rsp_stall);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr     <= req.line_address[AW-1:0];
      is_write <= req.is_write;
    end
  end

  drbt_div #(
    .AW (AW)
  ) u_div (
    .addr           (addr),
    .line_size_log2 (line_size_log2),
    .bank           (bank),
    .row            (row)
  );

  drbt_ram #(
    .WIDTH (AW),
    .DEPTH (drbt_pkg::NUM_BANKS)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (bank),
    .wdata (row),
    .re    (ram_re),
    .raddr (req.line_address[BW-1:0]),
    .rdata (open_row)
  );

  always_comb begin
    row_hit = bank_valid[bank] && (open_row == row);
    ram_we  = 1'b0;
    if (!row_model_enable) begin
      lat  = fixed_latency;
      kind = drbt_pkg::KIND_FIXED;
    end else if (page_policy_closed) begin
      lat  = drbt_pkg::LAT_W'(activate_cycles) + drbt_pkg::LAT_W'(column_cycles)
           + drbt_pkg::LAT_W'(transfer_cycles);
      kind = drbt_pkg::KIND_EMPTY;
    end else if (!bank_valid[bank]) begin
      lat    = drbt_pkg::LAT_W'(activate_cycles) + drbt_pkg::LAT_W'(column_cycles)
             + drbt_pkg::LAT_W'(transfer_cycles);
      kind   = drbt_pkg::KIND_EMPTY;
      ram_we = commit;
    end else if (row_hit) begin
      lat  = drbt_pkg::LAT_W'(column_cycles) + drbt_pkg::LAT_W'(transfer_cycles);
      kind = drbt_pkg::KIND_HIT;
    end else begin
      lat    = drbt_pkg::LAT_W'(precharge_cycles) + drbt_pkg::LAT_W'(activate_cycles)
             + drbt_pkg::LAT_W'(column_cycles) + drbt_pkg::LAT_W'(transfer_cycles);
      kind   = drbt_pkg::KIND_CONFLICT;
      ram_we = commit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_valid <= '0;
    end else if (commit && row_model_enable) begin
      bank_valid[bank] <= !page_policy_closed;
    end
  end

  assign upd = '{valid: commit, is_write: is_write, latency: lat};

  drbt_stats u_stats (
    .clk (clk),
    .rst (rst),
    .upd (upd),
    .tot (tot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      latency     <= lat;
      access_kind <= kind;
    end
  end

  always_comb begin
    rsp.latency           = latency;
    rsp.access_kind       = access_kind;
    rsp.read_count        = tot.read_count;
    rsp.write_count       = tot.write_count;
    rsp.read_delay_total  = tot.read_delay_total;
    rsp.write_delay_total = tot.write_delay_total;
  end

`ifndef SYNTHESIS
  a_eval_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == drbt_pkg::ST_EVAL)
    else $error("accepted transaction not evaluated");

  a_no_ram_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_re && ram_we))
    else $error("row RAM read and written in the same cycle");

  a_write_sets_valid: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> bank_valid[$past(bank)])
    else $error("open row written without marking the bank valid");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    commit |=> rsp_valid)
    else $error("committed transaction not presented");

  a_totals_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> $stable(tot))
    else $error("totals changed under a stalled response");
`endif

endmodule
